// ----- hw/rtl/bts_pkg.sv -----
package bts_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ADDR_BITS  = 16;
  localparam int MAX_TEXELS = 1 << ADDR_BITS;
  localparam int SIZE_BITS  = 9;
  localparam int COORD_BITS = 18;
  localparam int CH_BITS    = 8;
  localparam int OUT_BITS   = 16;
  localparam int IN_DATA_BITS  = 80;
  localparam int OUT_DATA_BITS = 48;

  localparam logic [SIZE_BITS-1:0] SIZE_MIN = 9'd2;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = 9'd256;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS-1:0] r;
    if (s < SIZE_MIN) r = SIZE_MIN;
    else if (s > SIZE_MAX) r = SIZE_MAX;
    else r = s;
    return r;
  endfunction

endpackage

// ----- hw/rtl/bilinear_texture_sampler.sv -----
// Words pass through stages 1 to 5 and an output register; loads give no output.
// Throughput: one word per cycle, loads and samples alike, while not stalled.
// The rate is set by four copies of the texture memory, one read port per corner.
// Reset clears all pipeline valid bits and sets width and height to 256.
// The texture memory is not cleared; it holds what loads have written.
module bilinear_texture_sampler (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: texel_addr, red_in, green_in, blue_in, coord_u, coord_v, zero pad
  input  logic [bts_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  // tuser: command
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: red_out, green_out, blue_out
  output logic [bts_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic cfg_addr,
  input  logic [bts_pkg::SIZE_BITS-1:0] cfg_wdata
);
  import bts_pkg::*;

  logic [SIZE_BITS-1:0] tex_width, tex_height;
  logic [SIZE_BITS-1:0] w_eff, h_eff;
  logic [7:0] wm1, hm1;
  logic en;

  // Stage 1: captured input word.
  logic v1, cmd1;
  logic [ADDR_BITS-1:0] addr1;
  logic [23:0] rgb1;
  logic [COORD_BITS-1:0] u1, v1c;
  // Stage 2: corners and fractions.
  logic v2, cmd2;
  logic [ADDR_BITS-1:0] addr2;
  logic [23:0] rgb2;
  logic [7:0] x0_2, y0_2;
  logic [FRAC_BITS-1:0] s2, t2;
  // Stage 3: texel addresses and weights.
  logic v3, cmd3;
  logic [ADDR_BITS-1:0] addr3;
  logic [23:0] rgb3;
  logic [ADDR_BITS-1:0] ta3 [4];
  logic [32:0] wt3 [4];
  // Stage 4: texels read.
  logic v4;
  logic [23:0] rd4 [4];
  logic [32:0] wt4 [4];
  // Stage 5: weighted channels.
  logic v5;
  logic [40:0] prod5 [3][4];

  logic [16:0] cu, cv, s_c, t_c;
  logic [24:0] su, sv;
  logic [7:0] x1, y1;
  logic [15:0] row0, row1;

  assign w_eff = eff_size(tex_width);
  assign h_eff = eff_size(tex_height);
  assign wm1 = 8'(w_eff - 9'd1);
  assign hm1 = 8'(h_eff - 9'd1);
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SIZE_MAX;
      tex_height <= SIZE_MAX;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_WIDTH:  tex_width  <= cfg_wdata;
        REG_HEIGHT: tex_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Coordinates are clamped to [0, 1] before scaling.
  always_comb begin
    if (u1[COORD_BITS-1]) cu = '0;
    else if (u1 > 18'(1 << FRAC_BITS)) cu = 17'(1 << FRAC_BITS);
    else cu = u1[16:0];
    if (v1c[COORD_BITS-1]) cv = '0;
    else if (v1c > 18'(1 << FRAC_BITS)) cv = 17'(1 << FRAC_BITS);
    else cv = v1c[16:0];
    su = cu * wm1;
    sv = cv * hm1;
    x1 = (x0_2 == wm1) ? wm1 : 8'(x0_2 + 8'd1);
    y1 = (y0_2 == hm1) ? hm1 : 8'(y0_2 + 8'd1);
    row0 = 16'({9'd0, y0_2} * {8'd0, w_eff});
    row1 = 16'({9'd0, y1} * {8'd0, w_eff});
    s_c = 17'(1 << FRAC_BITS) - {1'b0, s2};
    t_c = 17'(1 << FRAC_BITS) - {1'b0, t2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && (cmd3 == CMD_SAMPLE);
      v5 <= v4;
      m_axis_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1  <= s_axis_tuser;
      addr1 <= s_axis_tdata[15:0];
      rgb1  <= s_axis_tdata[39:16];
      u1    <= s_axis_tdata[57:40];
      v1c   <= s_axis_tdata[75:58];

      cmd2  <= cmd1;
      addr2 <= addr1;
      rgb2  <= rgb1;
      x0_2  <= su[23:16];
      y0_2  <= sv[23:16];
      s2    <= su[15:0];
      t2    <= sv[15:0];

      cmd3  <= cmd2;
      addr3 <= addr2;
      rgb3  <= rgb2;
      ta3[0] <= row0 + 16'(x0_2);
      ta3[1] <= row0 + 16'(x1);
      ta3[2] <= row1 + 16'(x0_2);
      ta3[3] <= row1 + 16'(x1);
      wt3[0] <= {16'd0, s_c} * {16'd0, t_c};
      wt3[1] <= {17'd0, s2} * {16'd0, t_c};
      wt3[2] <= {16'd0, s_c} * {17'd0, t2};
      wt3[3] <= {17'd0, s2} * {17'd0, t2};

      wt4 <= wt3;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod5[c][k] <= wt4[k] * rd4[k][8*c +: 8];
        end
      end
    end
  end

  // One memory copy per corner; loads write every copy in pipeline order.
  for (genvar k = 0; k < 4; k++) begin : g_mem
    logic [23:0] mem [MAX_TEXELS];
    always_ff @(posedge clk) begin
      if (en && v3 && (cmd3 == CMD_LOAD)) mem[addr3] <= rgb3;
      if (en && v3 && (cmd3 == CMD_SAMPLE)) rd4[k] <= mem[ta3[k]];
    end
  end

  logic [40:0] acc [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = prod5[c][0] + prod5[c][1] + prod5[c][2] + prod5[c][3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {acc[2][39:24], acc[1][39:24], acc[0][39:24]};
    end
  end

`ifndef SYNTHESIS
  a_upper_corner: assert property (@(posedge clk) disable iff (rst)
    v2 && (cmd2 == CMD_SAMPLE) |-> (x1 >= x0_2) && (x1 <= wm1) && (y1 <= hm1))
    else $error("upper corner out of range");
  a_red_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'hFF00)
    else $error("red out of range");
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(rd4[0]) && $stable(rd4[3]))
    else $error("read data changed during stall");
  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    v3 && (cmd3 == CMD_SAMPLE) |->
      35'(wt3[0]) + 35'(wt3[1]) + 35'(wt3[2]) + 35'(wt3[3]) == 35'(64'd1 << 32))
    else $error("weights do not sum to one");
`endif

endmodule
